// ----- rtl/core/lrf_pkg.sv -----
// Shared types and constants for the log record framer ring.
// Used by the front, back, result queue and top level; depends on nothing.
`timescale 1ns / 1ps

package lrf_pkg;

  // Default ring depth in bytes.
  localparam int BUF_DEPTH_DEF = 4096;

  // Field widths fixed by the interface.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int HELD_W     = 12;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LOG_EN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OVR_EN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLK_THR  = 2'd2;

  localparam logic [CFG_DATA_W-1:0] BLK_THR_RESET = 12'd512;

  // Record framing bytes.
  localparam logic [7:0] SYNC_FIRST  = 8'hC5;
  localparam logic [7:0] SYNC_SECOND = 8'hA3;

  // Request codes on the input channel.
  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  // Command kinds after classification.
  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_SKIP   = 2'd2;

  // Byte slots of one framed append, in storage order.
  localparam logic [2:0] STEP_SYNC1 = 3'd0;
  localparam logic [2:0] STEP_SYNC2 = 3'd1;
  localparam logic [2:0] STEP_TYPE  = 3'd2;
  localparam logic [2:0] STEP_LENLO = 3'd3;
  localparam logic [2:0] STEP_LENHI = 3'd4;
  localparam logic [2:0] STEP_DATA  = 3'd5;
  localparam logic [2:0] STEP_SUMA  = 3'd6;
  localparam logic [2:0] STEP_SUMB  = 3'd7;

  typedef struct packed {
    logic                  append_en;
    logic                  overrun_check_enable;
    logic [CFG_DATA_W-1:0] block_threshold;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        first;
    logic        last;
    logic [7:0]  rtype;
    logic [15:0] rlen;
    logic [7:0]  data;
  } cmd_t;

  typedef struct packed {
    logic [7:0]        read_byte;
    logic              read_valid;
    logic [HELD_W-1:0] bytes_held;
    logic              block_ready;
    logic              overrun_flag;
  } res_t;

endpackage

// ----- rtl/core/lrf_front.sv -----
// Front end: configuration registers, request classification and a
// two-entry command queue toward the back end. Depends on lrf_pkg.
`timescale 1ns / 1ps

module lrf_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [lrf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           push,
  output logic                           full,
  input  logic                           req_type,
  input  logic [7:0]                     record_type,
  input  logic [15:0]                    record_length,
  input  logic [7:0]                     data_byte,
  input  logic                           first_of_record,
  input  logic                           last_of_record,
  output lrf_pkg::cfg_t                  cfg,
  output lrf_pkg::cmd_t                  cmd,
  output logic                           cmd_valid,
  input  logic                           cmd_pop
);
  import lrf_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       cls;
  logic       do_push;
  logic       do_pop;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.append_en            <= 1'b0;
      cfg.overrun_check_enable <= 1'b0;
      cfg.block_threshold      <= BLK_THR_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LOG_EN:  cfg.append_en            <= cfg_data[0];
        REG_OVR_EN:  cfg.overrun_check_enable <= cfg_data[0];
        REG_BLK_THR: cfg.block_threshold      <= cfg_data;
        default: ;
      endcase
    end
  end

  // Classify the incoming request; appends while logging is off store nothing.
  always_comb begin
    cls.first = first_of_record;
    cls.last  = last_of_record;
    cls.rtype = record_type;
    cls.rlen  = record_length;
    cls.data  = data_byte;
    if (req_type == REQ_READ) begin
      cls.kind = CMD_READ;
    end else if (cfg.append_en) begin
      cls.kind = CMD_APPEND;
    end else begin
      cls.kind = CMD_SKIP;
    end
  end

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= cls;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/core/lrf_back.sv -----
// Back end: byte sequencer over the ring memory, pointers, Fletcher sums
// and overrun flag; builds one result per command. Depends on lrf_pkg.
`timescale 1ns / 1ps

module lrf_back #(
  parameter int BufDepth = lrf_pkg::BUF_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  lrf_pkg::cfg_t cfg,
  input  lrf_pkg::cmd_t cmd,
  input  logic          cmd_valid,
  output logic          cmd_pop,
  output lrf_pkg::res_t res,
  output logic          res_push,
  input  logic          res_full
);
  import lrf_pkg::*;

  localparam int PW = $clog2(BufDepth);
  localparam logic [PW-1:0] LAST_ADDR = PW'(BufDepth - 1);
  localparam logic [PW:0]   DEPTH_W   = (PW + 1)'(BufDepth);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_WRITE  = 2'd1;
  localparam logic [1:0] ST_RDWAIT = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  logic [7:0]    mem [BufDepth];
  logic [7:0]    rdata;

  logic [1:0]    state;
  logic [1:0]    state_next;
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [PW-1:0] wp_next;
  logic [7:0]    sum_first;
  logic [7:0]    sum_second;
  logic [7:0]    sumb_hold;
  logic          overrun;
  logic [2:0]    step;
  logic [2:0]    last_step;
  cmd_t          cur;
  logic          res_rvalid;

  logic          mem_we;
  logic          mem_re;
  logic [7:0]    wbyte;
  logic [7:0]    sum_first_upd;
  logic [PW:0]   held_w;
  logic [HELD_W-1:0] held;

  assign wp_next = (wp == LAST_ADDR) ? '0 : wp + 1'b1;

  // Byte for the current slot of the framed record.
  always_comb begin
    unique case (step)
      STEP_SYNC1: wbyte = SYNC_FIRST;
      STEP_SYNC2: wbyte = SYNC_SECOND;
      STEP_TYPE:  wbyte = cur.rtype;
      STEP_LENLO: wbyte = cur.rlen[7:0];
      STEP_LENHI: wbyte = cur.rlen[15:8];
      STEP_DATA:  wbyte = cur.data;
      STEP_SUMA:  wbyte = sum_first;
      STEP_SUMB:  wbyte = sumb_hold;
      default:    wbyte = cur.data;
    endcase
  end

  assign sum_first_upd = sum_first + wbyte;

  // Held byte count, wrapped to the ring depth.
  always_comb begin
    if (wp >= rp) begin
      held_w = {1'b0, wp} - {1'b0, rp};
    end else begin
      held_w = {1'b0, wp} + DEPTH_W - {1'b0, rp};
    end
    held = HELD_W'(held_w);
  end

  assign mem_we  = (state == ST_WRITE);
  assign mem_re  = (state == ST_IDLE) && cmd_valid && (cmd.kind == CMD_READ) && (wp != rp);
  assign cmd_pop = (state == ST_IDLE) && cmd_valid;

  // Result fields from the state left by the command.
  assign res.read_byte    = res_rvalid ? rdata : 8'd0;
  assign res.read_valid   = res_rvalid;
  assign res.bytes_held   = held;
  assign res.block_ready  = (held >= cfg.block_threshold);
  assign res.overrun_flag = overrun;
  assign res_push         = (state == ST_DONE) && !res_full;

  // Ring memory, one access per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp] <= wbyte;
    end else if (mem_re) begin
      rdata <= mem[rp];
    end
  end

  // Next-state decode.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.kind == CMD_APPEND) begin
            state_next = ST_WRITE;
          end else if (mem_re) begin
            state_next = ST_RDWAIT;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_WRITE: begin
        if (step == last_step) begin
          state_next = ST_DONE;
        end
      end
      ST_RDWAIT: state_next = ST_DONE;
      ST_DONE: begin
        if (!res_full) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Command latch and slot range.
  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur       <= cmd;
      step      <= cmd.first ? STEP_SYNC1 : STEP_DATA;
      last_step <= cmd.last ? STEP_SUMB : STEP_DATA;
    end else if (state == ST_WRITE) begin
      step <= step + 3'd1;
    end
    if (state == ST_WRITE && step == STEP_SUMA) begin
      sumb_hold <= sum_second;
    end
  end

  // Control state, pointers, sums and overrun flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      wp         <= '0;
      rp         <= '0;
      sum_first  <= 8'd0;
      sum_second <= 8'd0;
      overrun    <= 1'b0;
      res_rvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd_pop) begin
        res_rvalid <= mem_re;
      end
      if (mem_re) begin
        rp <= (rp == LAST_ADDR) ? '0 : rp + 1'b1;
      end
      if (mem_we) begin
        wp <= wp_next;
        if (wp_next == rp && cfg.overrun_check_enable) begin
          overrun <= 1'b1;
        end
        if (step == STEP_SYNC2) begin
          sum_first  <= 8'd0;
          sum_second <= 8'd0;
        end else begin
          sum_first  <= sum_first_upd;
          sum_second <= sum_second + sum_first_upd;
        end
      end
    end
  end

endmodule

// ----- rtl/core/lrf_outq.sv -----
// Two-entry result queue that decouples the back end from the reader.
// Depends on lrf_pkg.
`timescale 1ns / 1ps

module lrf_outq (
  input  logic          clk,
  input  logic          rst,
  input  lrf_pkg::res_t in_res,
  input  logic          in_push,
  output logic          in_full,
  output lrf_pkg::res_t out_res,
  output logic          empty,
  input  logic          pop
);
  import lrf_pkg::*;

  res_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign in_full = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign out_res = q[rd_ptr];
  assign do_push = in_push && !in_full;
  assign do_pop  = pop && !empty;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= in_res;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/core/log_record_framer_ring.sv -----
// Top level of the log record framer ring.
// Depends on lrf_pkg, lrf_front, lrf_back and lrf_outq.
//
// Usage:
//   Input channel: a request transfers at a clock edge with push high and
//   full low. req_type selects an append (one payload byte, with optional
//   header before it and checksum bytes after it) or a read of one byte.
//   Result channel: every request yields exactly one result, in order. The
//   oldest result sits on the result ports while empty is low and transfers
//   at a clock edge with pop high.
//   Configuration: cfg_write with cfg_index and cfg_data writes one register
//   in the same cycle; write only while no request is outstanding.
//   Timing: the back end works on one request at a time: an append storing
//   N bytes (1 to 8) goes idle, write, done; a read idle, read-wait, done; an
//   ignored append or an empty read idle, done. The single-port ring memory
//   takes one byte a cycle. Each result is registered in the result queue.
//   Stalls: a two-entry request queue and a two-entry result queue sit on
//   either side, so new requests are taken while results wait; when the
//   result queue fills the back end holds its finished result.
//   Reset (rst, synchronous): pointers, sums, overrun flag and queues clear,
//   registers return to their defaults; ring contents are left as they are.
`timescale 1ns / 1ps

module log_record_framer_ring #(
  parameter int BufDepth = lrf_pkg::BUF_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [lrf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           push,
  output logic                           full,
  input  logic                           req_type,
  input  logic [7:0]                     record_type,
  input  logic [15:0]                    record_length,
  input  logic [7:0]                     data_byte,
  input  logic                           first_of_record,
  input  logic                           last_of_record,
  output logic                           empty,
  input  logic                           pop,
  output logic [7:0]                     read_byte,
  output logic                           read_valid,
  output logic [lrf_pkg::HELD_W-1:0]     bytes_held,
  output logic                           block_ready,
  output logic                           overrun_flag
);
  import lrf_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;
  res_t back_res;
  logic res_push;
  logic res_full;
  res_t out_res;

  // Request intake and classification.
  lrf_front u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .push            (push),
    .full            (full),
    .req_type        (req_type),
    .record_type     (record_type),
    .record_length   (record_length),
    .data_byte       (data_byte),
    .first_of_record (first_of_record),
    .last_of_record  (last_of_record),
    .cfg             (cfg),
    .cmd             (cmd),
    .cmd_valid       (cmd_valid),
    .cmd_pop         (cmd_pop)
  );

  // Ring sequencer.
  lrf_back #(
    .BufDepth (BufDepth)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .res       (back_res),
    .res_push  (res_push),
    .res_full  (res_full)
  );

  // Result queue.
  lrf_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .in_res  (back_res),
    .in_push (res_push),
    .in_full (res_full),
    .out_res (out_res),
    .empty   (empty),
    .pop     (pop)
  );

  assign read_byte    = out_res.read_byte;
  assign read_valid   = out_res.read_valid;
  assign bytes_held   = out_res.bytes_held;
  assign block_ready  = out_res.block_ready;
  assign overrun_flag = out_res.overrun_flag;

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for log_record_framer_ring: a directed table, then
// phased random traffic checked against a ring and framing predictor.
// Depends on lrf_pkg and the log_record_framer_ring top level.
`timescale 1ns / 1ps

module tb;
  import lrf_pkg::*;

  localparam int RING_DEPTH  = BUF_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_WAIT = 16;

  // One request as offered on the input side.
  typedef struct packed {
    logic        req_type;
    logic [7:0]  record_type;
    logic [15:0] record_length;
    logic [7:0]  data_byte;
    logic        first;
    logic        last;
  } log_req_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  // One line of the directed table: a register write or a request.
  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_val;
    log_req_t              item;
    bit                    has_known;
    res_t                  known_res;
  } dir_row_t;

  logic                  clk             = 1'b0;
  logic                  rst             = 1'b1;
  logic                  cfg_write       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index       = '0;
  logic [CFG_DATA_W-1:0] cfg_data        = '0;
  logic                  push            = 1'b0;
  logic                  full;
  logic                  req_type        = 1'b0;
  logic [7:0]            record_type     = '0;
  logic [15:0]           record_length   = '0;
  logic [7:0]            data_byte       = '0;
  logic                  first_of_record = 1'b0;
  logic                  last_of_record  = 1'b0;
  logic                  empty;
  logic                  pop             = 1'b0;
  logic [7:0]            read_byte;
  logic                  read_valid;
  logic [HELD_W-1:0]     bytes_held;
  logic                  block_ready;
  logic                  overrun_flag;

  // Predictor state: ring image, pointers, running sums and registers.
  logic [7:0]            ring_img [RING_DEPTH];
  int unsigned           wr_ptr   = 0;
  int unsigned           rd_ptr   = 0;
  logic [7:0]            fsum_a   = '0;
  logic [7:0]            fsum_b   = '0;
  bit                    ovr_seen = 1'b0;
  bit                    log_en_m = 1'b0;
  bit                    ovr_en_m = 1'b0;
  logic [CFG_DATA_W-1:0] thr_m    = BLK_THR_RESET;

  res_t     expected_results[$];
  dir_row_t dir_rows[$];
  int       rec_left      = 0;
  int       tx_idle_pct   = 0;
  int       rx_idle_pct   = 0;
  int       rx_hold       = 0;
  int       n_errors      = 0;
  int       n_sent        = 0;
  int       n_checked     = 0;
  int       n_read_hits   = 0;
  int       n_full_stalls = 0;
  int       peak_held     = 0;
  int       cycle_count   = 0;

  log_record_framer_ring dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .push            (push),
    .full            (full),
    .req_type        (req_type),
    .record_type     (record_type),
    .record_length   (record_length),
    .data_byte       (data_byte),
    .first_of_record (first_of_record),
    .last_of_record  (last_of_record),
    .empty           (empty),
    .pop             (pop),
    .read_byte       (read_byte),
    .read_valid      (read_valid),
    .bytes_held      (bytes_held),
    .block_ready     (block_ready),
    .overrun_flag    (overrun_flag)
  );

  always #6 clk = ~clk;

  // Run limit: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached, %0d results outstanding", $time,
               expected_results.size());
      $display("log_record_framer_ring regression: fail");
      $finish;
    end
  end

  function automatic int unsigned held_now();
    return (wr_ptr + RING_DEPTH - rd_ptr) % RING_DEPTH;
  endfunction

  // Stores one byte, folds it into both sums and advances the write side.
  function automatic void ring_put(logic [7:0] b);
    int unsigned nxt;
    ring_img[wr_ptr] = b;
    fsum_a = fsum_a + b;
    fsum_b = fsum_b + fsum_a;
    nxt = (wr_ptr + 1) % RING_DEPTH;
    if (nxt == rd_ptr && ovr_en_m) ovr_seen = 1'b1;
    wr_ptr = nxt;
  endfunction

  // Applies one request to the predictor and returns the status it reports.
  function automatic res_t frame_predict(log_req_t r);
    res_t        o;
    logic [7:0]  sa;
    logic [7:0]  sb;
    int unsigned held;
    o = '0;
    if (r.req_type == REQ_APPEND) begin
      if (log_en_m) begin
        if (r.first) begin
          ring_put(SYNC_FIRST);
          ring_put(SYNC_SECOND);
          // The sums start over after the sync pair.
          fsum_a = '0;
          fsum_b = '0;
          ring_put(r.record_type);
          ring_put(r.record_length[7:0]);
          ring_put(r.record_length[15:8]);
        end
        ring_put(r.data_byte);
        if (r.last) begin
          sa = fsum_a;
          sb = fsum_b;
          ring_put(sa);
          ring_put(sb);
        end
      end
    end else if (held_now() != 0) begin
      o.read_byte  = ring_img[rd_ptr];
      o.read_valid = 1'b1;
      rd_ptr = (rd_ptr + 1) % RING_DEPTH;
      n_read_hits++;
    end
    held = held_now();
    if (held > peak_held) peak_held = held;
    o.bytes_held   = HELD_W'(held);
    o.block_ready  = (held >= thr_m);
    o.overrun_flag = ovr_seen;
    return o;
  endfunction

  // Random request: mostly well-formed records, some broken framing, reads.
  function automatic log_req_t next_item(int read_pct, int single_pct);
    log_req_t r;
    r.req_type      = REQ_APPEND;
    r.record_type   = 8'($urandom);
    r.record_length = 16'($urandom);
    r.data_byte     = 8'($urandom);
    r.first         = 1'b0;
    r.last          = 1'b0;
    if ($urandom_range(99) < read_pct) begin
      // Header and payload fields ride along unused on a read.
      r.req_type = REQ_READ;
      r.first    = 1'($urandom);
      r.last     = 1'($urandom);
    end else if ($urandom_range(99) < 8) begin
      // Broken framing: flags at random, regardless of the open record.
      r.first = 1'($urandom);
      r.last  = 1'($urandom);
    end else begin
      if (rec_left == 0) begin
        rec_left = ($urandom_range(99) < single_pct) ? 1 : int'($urandom_range(6, 2));
        r.first  = 1'b1;
        if ($urandom_range(99) < 70) r.record_length = 16'(rec_left);
      end
      rec_left--;
      r.last = (rec_left == 0);
    end
    return r;
  endfunction

  function automatic dir_row_t item_row(logic rq, logic [7:0] rtype, logic [15:0] rlen,
                                        logic [7:0] data, logic first, logic last);
    dir_row_t row;
    row.kind      = ROW_ITEM;
    row.cfg_idx   = '0;
    row.cfg_val   = '0;
    row.item      = '{rq, rtype, rlen, data, first, last};
    row.has_known = 1'b0;
    row.known_res = '0;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    dir_row_t row;
    row         = item_row(REQ_READ, '0, '0, '0, 1'b0, 1'b0);
    row.kind    = ROW_CFG;
    row.cfg_idx = idx;
    row.cfg_val = val;
    return row;
  endfunction

  // Typed-in result; every such row runs with the reset threshold and no overrun.
  function automatic dir_row_t known(dir_row_t row, logic [7:0] rb, logic rv,
                                     logic [HELD_W-1:0] held);
    row.has_known = 1'b1;
    row.known_res = '{rb, rv, held, 1'b0, 1'b0};
    return row;
  endfunction

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      n_errors++;
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
    end
  endfunction

  // Offers one request, waits for its transfer and records what it should yield.
  task automatic offer_item(input log_req_t r, input bit use_known, input res_t known_res);
    res_t predicted;
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push            <= 1'b1;
    req_type        <= r.req_type;
    record_type     <= r.record_type;
    record_length   <= r.record_length;
    data_byte       <= r.data_byte;
    first_of_record <= r.first;
    last_of_record  <= r.last;
    @(posedge clk);
    while (full) begin
      n_full_stalls++;
      @(posedge clk);
    end
    predicted = frame_predict(r);
    expected_results.push_back(use_known ? known_res : predicted);
    n_sent++;
  endtask

  // Stops offering and waits until every outstanding result has come back.
  task automatic settle_results();
    @(negedge clk);
    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    settle_results();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_LOG_EN:  log_en_m = val[0];
      REG_OVR_EN:  ovr_en_m = val[0];
      REG_BLK_THR: thr_m    = CFG_DATA_W'(val);
      default: ;
    endcase
  endtask

  // Result side: random or held-off pop, each transfer checked in order.
  initial begin : result_sink
    res_t got;
    res_t want;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        pop <= 1'b0;
        rx_hold--;
      end else begin
        pop <= ($urandom_range(99) >= rx_idle_pct);
      end
      @(posedge clk);
      if (pop && !empty) begin
        got = '{read_byte, read_valid, bytes_held, block_ready, overrun_flag};
        if (expected_results.size() == 0) begin
          n_errors++;
          $display("%0t: result with nothing expected: read_byte %0h read_valid %0b held %0d",
                   $time, read_byte, read_valid, bytes_held);
        end else begin
          want = expected_results.pop_front();
          n_checked++;
          compare_field("read_byte", 16'(want.read_byte), 16'(got.read_byte));
          compare_field("read_valid", 16'(want.read_valid), 16'(got.read_valid));
          compare_field("bytes_held", 16'(want.bytes_held), 16'(got.bytes_held));
          compare_field("block_ready", 16'(want.block_ready), 16'(got.block_ready));
          compare_field("overrun_flag", 16'(want.overrun_flag), 16'(got.overrun_flag));
        end
      end
    end
  end

  initial begin : stimulus
    int n;
    int extra;

    // Directed table: empty read, disabled append, header bytes, sums, thresholds.
    dir_rows.push_back(known(item_row(REQ_READ, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b0),
                             8'h00, 1'b0, 12'd0));
    dir_rows.push_back(known(item_row(REQ_APPEND, 8'hFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1),
                             8'h00, 1'b0, 12'd0));
    dir_rows.push_back(cfg_row(REG_LOG_EN, 12'd1));
    dir_rows.push_back(known(item_row(REQ_APPEND, 8'hFF, 16'hFFFF, 8'hFF, 1'b1, 1'b1),
                             8'h00, 1'b0, 12'd8));
    dir_rows.push_back(known(item_row(REQ_READ, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b0),
                             SYNC_FIRST, 1'b1, 12'd7));
    dir_rows.push_back(known(item_row(REQ_READ, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b0),
                             SYNC_SECOND, 1'b1, 12'd6));
    dir_rows.push_back(known(item_row(REQ_READ, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b0),
                             8'hFF, 1'b1, 12'd5));
    dir_rows.push_back(known(item_row(REQ_READ, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b0),
                             8'hFF, 1'b1, 12'd4));
    dir_rows.push_back(known(item_row(REQ_READ, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b0),
                             8'hFF, 1'b1, 12'd3));
    dir_rows.push_back(known(item_row(REQ_READ, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b0),
                             8'hFF, 1'b1, 12'd2));
    dir_rows.push_back(item_row(REQ_READ, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b0));
    dir_rows.push_back(item_row(REQ_READ, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b0));
    dir_rows.push_back(known(item_row(REQ_READ, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b0),
                             8'h00, 1'b0, 12'd0));
    dir_rows.push_back(known(item_row(REQ_APPEND, 8'h00, 16'h0000, 8'h00, 1'b1, 1'b0),
                             8'h00, 1'b0, 12'd6));
    dir_rows.push_back(item_row(REQ_APPEND, 8'h00, 16'h0000, 8'h5A, 1'b0, 1'b0));
    dir_rows.push_back(item_row(REQ_APPEND, 8'h00, 16'h0000, 8'hA5, 1'b0, 1'b1));
    // A last byte with no header keeps summing over the stored sum bytes.
    dir_rows.push_back(item_row(REQ_APPEND, 8'h00, 16'h0000, 8'h3C, 1'b0, 1'b1));
    dir_rows.push_back(cfg_row(REG_BLK_THR, 12'd1));
    dir_rows.push_back(item_row(REQ_READ, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b0));
    dir_rows.push_back(cfg_row(REG_BLK_THR, 12'd0));
    dir_rows.push_back(cfg_row(REG_OVR_EN, 12'd1));
    dir_rows.push_back(item_row(REQ_APPEND, 8'h80, 16'h0100, 8'h01, 1'b1, 1'b1));
    dir_rows.push_back(item_row(REQ_APPEND, 8'h7F, 16'h00FF, 8'h80, 1'b1, 1'b0));
    dir_rows.push_back(item_row(REQ_READ, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b0));
    dir_rows.push_back(item_row(REQ_READ, 8'h00, 16'h0000, 8'h00, 1'b0, 1'b0));

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    tx_idle_pct = 13;
    rx_idle_pct = 67;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        program_reg(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
      end else begin
        offer_item(dir_rows[i].item, dir_rows[i].has_known, dir_rows[i].known_res);
      end
    end

    // Mixed traffic at a low threshold; the result side stops for a long
    // stretch so both queues fill and the input stalls.
    program_reg(REG_OVR_EN, 0);
    program_reg(REG_BLK_THR, $urandom_range(64, 1));
    for (n = 0; n < 200; n++) begin
      if (n == 60) rx_hold = 400;
      offer_item(next_item(50, 60), 1'b0, '0);
    end

    // Append-heavy fill with overrun checking until the ring laps the reader.
    tx_idle_pct = 67;
    rx_idle_pct = 13;
    program_reg(REG_BLK_THR, 4095);
    program_reg(REG_OVR_EN, 1);
    extra = 0;
    for (n = 0; n < 1000 && extra < 40; n++) begin
      offer_item(next_item(3, 90), 1'b0, '0);
      if (ovr_seen) extra++;
    end

    // Read-heavy drain with a zero threshold, down to and past empty.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    program_reg(REG_OVR_EN, 0);
    program_reg(REG_BLK_THR, 0);
    extra = 0;
    for (n = 0; n < 1000 && extra < 30; n++) begin
      offer_item(next_item(95, 60), 1'b0, '0);
      if (held_now() == 0) extra++;
    end

    // Logging off: appends leave the ring alone.
    program_reg(REG_LOG_EN, 0);
    program_reg(REG_BLK_THR, 512);
    for (n = 0; n < 60; n++) offer_item(next_item(50, 60), 1'b0, '0);

    // Logging back on with a random threshold and checking on.
    program_reg(REG_LOG_EN, 1);
    program_reg(REG_OVR_EN, 1);
    program_reg(REG_BLK_THR, $urandom_range(4095, 1));
    for (n = 0; n < 150; n++) offer_item(next_item(40, 50), 1'b0, '0);

    settle_results();
    repeat (SETTLE_WAIT) @(posedge clk);

    $display("Sent %0d requests, checked %0d results, %0d reads returned a byte.",
             n_sent, n_checked, n_read_hits);
    $display("Input stalled %0d cycles, peak fill %0d bytes, overrun %0s.",
             n_full_stalls, peak_held, ovr_seen ? "reached" : "not reached");
    if (n_errors == 0) begin
      $display("log_record_framer_ring regression: pass");
    end else begin
      $display("log_record_framer_ring regression: fail");
    end
    $finish;
  end

endmodule

// ----- log_record_framer_ring.f -----
rtl/core/lrf_pkg.sv
rtl/core/lrf_front.sv
rtl/core/lrf_back.sv
rtl/core/lrf_outq.sv
rtl/core/log_record_framer_ring.sv
sim/tb.sv
